### design/sctok_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sctok_pkg;

  // Result kinds.
  typedef enum logic [2:0] {
    KIND_NUMBER    = 3'd0,
    KIND_ID_CLOSE  = 3'd1,
    KIND_STR_CLOSE = 3'd2,
    KIND_SYMBOL    = 3'd3,
    KIND_TEXT_CHAR = 3'd4,
    KIND_ERROR     = 3'd5,
    KIND_END       = 3'd6
  } kind_t;

  // Scanner modes.
  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_NUMBER  = 3'd1,
    MODE_IDENT   = 3'd2,
    MODE_STRING  = 3'd3,
    MODE_PENDING = 3'd4,
    MODE_COMMENT = 3'd5,
    MODE_HALTED  = 3'd6
  } mode_t;

  localparam int unsigned MAX_RECS = 3;

  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_BANG    = 8'h21;
  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_LPAREN  = 8'h28;
  localparam logic [7:0] CH_RPAREN  = 8'h29;
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_COMMA   = 8'h2C;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_LT      = 8'h3C;
  localparam logic [7:0] CH_EQ      = 8'h3D;
  localparam logic [7:0] CH_GT      = 8'h3E;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_UNDER   = 8'h5F;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;
  localparam logic [7:0] CH_LBRACE  = 8'h7B;
  localparam logic [7:0] CH_RBRACE  = 8'h7D;

  localparam logic [15:0] LEN_MAX = 16'hFFFF;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       is_last;
  } in_item_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] number_value;
    logic [7:0]  symbol_first;
    logic [7:0]  symbol_second;
    logic [7:0]  text_byte;
    logic [15:0] text_length;
    logic        last_of_run;
  } out_item_t;

  // All records caused by one input byte, in order.
  typedef struct packed {
    logic [1:0]                   count;
    out_item_t [MAX_RECS-1:0]     recs;
  } run_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

`default_nettype wire

### design/source_char_tokenizer_core.sv
// Byte-serial source tokenizer.
// The input channel (in_valid, in_ready, in_data) takes one source byte per
// transaction, with is_last marking the final byte of a text. A zero byte
// also ends the text. The result channel (out_valid, out_ready, out_data)
// delivers one token record per transaction, and last_of_run flags the final
// record caused by a given byte. A byte may cause zero to three records.
// The front end lexes a byte in the cycle it is accepted and writes all of
// its records as one entry into a small queue; the back end drains that
// queue one record per cycle, while the receiver is ready, into a
// registered output stage. The first record of a byte passes through the
// queue and then the output register. Throughput: one byte per cycle while
// the queue is not full, limited by the output to one record per cycle, so
// a byte's records leave in turn while the queue keeps accepting input.
// When the receiver stalls, the output register holds its record, the queue
// fills, and in_ready drops once QUEUE_DEPTH entries are waiting.
// Reset (rst_n low at a clock edge) returns the scanner to idle, empties the
// queue and clears out_valid. After an error record the block takes input
// but produces nothing further until reset.
`timescale 1ns / 1ps
`default_nettype none

module source_char_tokenizer_core #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire sctok_pkg::in_item_t   in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output sctok_pkg::out_item_t       out_data
);
  import sctok_pkg::*;

  // Entries between the lexer and the output sequencer.
  logic      push;
  run_t      push_data;
  logic      pop;
  run_t      head;
  q_status_t q_status;

  sctok_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .q_status  (q_status),
    .push      (push),
    .push_data (push_data)
  );

  sctok_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .q_status  (q_status)
  );

  sctok_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .q_status  (q_status),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

### design/sctok_front.sv
`timescale 1ns / 1ps
`default_nettype none

module sctok_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire sctok_pkg::in_item_t in_data,
  input  wire sctok_pkg::q_status_t q_status,
  output logic                    push,
  output sctok_pkg::run_t         push_data
);
  import sctok_pkg::*;

  mode_t       mode_r, mode_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [7:0]  pend_r, pend_nxt;
  logic [15:0] cnt_r, cnt_nxt;
  run_t        run;
  logic        accept;

  function automatic logic is_blank(logic [7:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return (c >= CH_LOWER_A && c <= CH_LOWER_Z) ||
           (c >= CH_UPPER_A && c <= CH_UPPER_Z) || (c == CH_UNDER);
  endfunction

  function automatic logic is_pair_op(logic [7:0] c);
    return (c == CH_EQ) || (c == CH_BANG) || (c == CH_LT) || (c == CH_GT);
  endfunction

  function automatic logic is_single_op(logic [7:0] c);
    return (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_STAR) ||
           (c == CH_LPAREN) || (c == CH_RPAREN) || (c == CH_COMMA) ||
           (c == CH_LBRACE) || (c == CH_RBRACE);
  endfunction

  function automatic out_item_t mk(kind_t k, logic [31:0] num, logic [7:0] s1,
                                   logic [7:0] s2, logic [7:0] tb, logic [15:0] len);
    out_item_t r;
    r.kind          = k;
    r.number_value  = num;
    r.symbol_first  = s1;
    r.symbol_second = s2;
    r.text_byte     = tb;
    r.text_length   = len;
    r.last_of_run   = 1'b0;
    return r;
  endfunction

  assign in_ready  = !q_status.full;
  assign accept    = in_valid && in_ready;
  assign push      = accept && (run.count != 2'd0);
  assign push_data = run;

  // One byte fully lexed in a single pass; records collect in order.
  always_comb begin
    logic [7:0]  c;
    logic        last;
    logic        fall;
    logic        alive;
    logic [7:0]  fold;
    logic [1:0]  n;
    out_item_t [MAX_RECS-1:0] recs;
    out_item_t   rec;
    logic        have;

    c        = in_data.char_byte;
    last     = in_data.is_last;
    mode_nxt = mode_r;
    acc_nxt  = acc_r;
    pend_nxt = pend_r;
    cnt_nxt  = cnt_r;
    fall     = 1'b1;
    alive    = 1'b1;
    fold     = CH_NUL;
    n        = 2'd0;
    recs     = '0;
    rec      = '0;
    have     = 1'b0;

    if (mode_r == MODE_HALTED) begin
      alive = 1'b0;
    end else begin
      if (c != CH_NUL) begin
        // Close or extend the open token.
        unique case (mode_r)
          MODE_NUMBER: begin
            if (is_digit(c)) begin
              acc_nxt = (acc_r << 3) + (acc_r << 1) + {24'd0, c - CH_ZERO};
              fall    = 1'b0;
            end else begin
              rec      = mk(KIND_NUMBER, acc_r, CH_NUL, CH_NUL, CH_NUL, 16'd0);
              have     = 1'b1;
              mode_nxt = MODE_IDLE;
            end
          end
          MODE_IDENT: begin
            if (is_alpha(c) || is_digit(c)) begin
              fall = 1'b0;
              if (cnt_nxt != LEN_MAX) cnt_nxt = cnt_nxt + 16'd1;
              if (last) fold = c;
              else begin
                rec  = mk(KIND_TEXT_CHAR, 32'd0, CH_NUL, CH_NUL, c, 16'd0);
                have = 1'b1;
              end
            end else begin
              rec      = mk(KIND_ID_CLOSE, 32'd0, CH_NUL, CH_NUL, CH_NUL, cnt_r);
              have     = 1'b1;
              mode_nxt = MODE_IDLE;
            end
          end
          MODE_STRING: begin
            fall = 1'b0;
            if (c == CH_QUOTE) begin
              rec      = mk(KIND_STR_CLOSE, 32'd0, CH_NUL, CH_NUL, CH_NUL, cnt_r);
              have     = 1'b1;
              mode_nxt = MODE_IDLE;
            end else begin
              if (cnt_nxt != LEN_MAX) cnt_nxt = cnt_nxt + 16'd1;
              if (last) fold = c;
              else begin
                rec  = mk(KIND_TEXT_CHAR, 32'd0, CH_NUL, CH_NUL, c, 16'd0);
                have = 1'b1;
              end
            end
          end
          MODE_PENDING: begin
            if (c == CH_EQ && is_pair_op(pend_r)) begin
              rec      = mk(KIND_SYMBOL, 32'd0, pend_r, CH_EQ, CH_NUL, 16'd0);
              have     = 1'b1;
              mode_nxt = MODE_IDLE;
              fall     = 1'b0;
            end else if (c == CH_SLASH && pend_r == CH_SLASH) begin
              mode_nxt = MODE_COMMENT;
              fall     = 1'b0;
            end else begin
              rec      = mk(KIND_SYMBOL, 32'd0, pend_r, CH_NUL, CH_NUL, 16'd0);
              have     = 1'b1;
              mode_nxt = MODE_IDLE;
            end
          end
          MODE_COMMENT: begin
            fall = 1'b0;
            if (c == CH_LF) mode_nxt = MODE_IDLE;
          end
          default: ;
        endcase
        if (have) begin
          recs[n] = rec;
          n       = n + 2'd1;
          have    = 1'b0;
        end

        // Start of a new token from the idle state.
        if (fall) begin
          priority if (is_blank(c)) begin
          end else if (is_digit(c)) begin
            mode_nxt = MODE_NUMBER;
            acc_nxt  = {24'd0, c - CH_ZERO};
          end else if (is_alpha(c)) begin
            mode_nxt = MODE_IDENT;
            cnt_nxt  = 16'd1;
            if (last) fold = c;
            else begin
              rec  = mk(KIND_TEXT_CHAR, 32'd0, CH_NUL, CH_NUL, c, 16'd0);
              have = 1'b1;
            end
          end else if (c == CH_QUOTE) begin
            mode_nxt = MODE_STRING;
            cnt_nxt  = 16'd0;
          end else if (is_pair_op(c) || c == CH_SLASH) begin
            mode_nxt = MODE_PENDING;
            pend_nxt = c;
          end else if (is_single_op(c)) begin
            rec  = mk(KIND_SYMBOL, 32'd0, c, CH_NUL, CH_NUL, 16'd0);
            have = 1'b1;
          end else begin
            rec      = mk(KIND_ERROR, 32'd0, CH_NUL, CH_NUL, c, 16'd0);
            have     = 1'b1;
            mode_nxt = MODE_HALTED;
            alive    = 1'b0;
          end
          if (have) begin
            recs[n] = rec;
            n       = n + 2'd1;
            have    = 1'b0;
          end
        end
      end

      // End of text: flush the open token, then the end marker.
      if (alive && (c == CH_NUL || last)) begin
        unique case (mode_nxt)
          MODE_NUMBER: begin
            rec  = mk(KIND_NUMBER, acc_nxt, CH_NUL, CH_NUL, CH_NUL, 16'd0);
            have = 1'b1;
          end
          MODE_IDENT: begin
            rec  = mk(KIND_ID_CLOSE, 32'd0, CH_NUL, CH_NUL, fold, cnt_nxt);
            have = 1'b1;
          end
          MODE_STRING: begin
            rec  = mk(KIND_STR_CLOSE, 32'd0, CH_NUL, CH_NUL, fold, cnt_nxt);
            have = 1'b1;
          end
          MODE_PENDING: begin
            rec  = mk(KIND_SYMBOL, 32'd0, pend_nxt, CH_NUL, CH_NUL, 16'd0);
            have = 1'b1;
          end
          default: ;
        endcase
        if (have && n != 2'd3) begin
          recs[n] = rec;
          n       = n + 2'd1;
        end
        if (n != 2'd3) begin
          recs[n] = mk(KIND_END, 32'd0, CH_NUL, CH_NUL, CH_NUL, 16'd0);
          n       = n + 2'd1;
        end
        mode_nxt = MODE_IDLE;
        acc_nxt  = 32'd0;
        pend_nxt = CH_NUL;
        cnt_nxt  = 16'd0;
      end
    end

    if (n != 2'd0) recs[n - 2'd1].last_of_run = 1'b1;
    run.count = n;
    run.recs  = recs;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      acc_r  <= 32'd0;
      pend_r <= CH_NUL;
      cnt_r  <= 16'd0;
    end else if (accept) begin
      mode_r <= mode_nxt;
      acc_r  <= acc_nxt;
      pend_r <= pend_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

### design/sctok_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module sctok_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  input  wire sctok_pkg::run_t      push_data,
  input  wire logic                 pop,
  output sctok_pkg::run_t           head,
  output sctok_pkg::q_status_t      q_status
);
  import sctok_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  run_t          mem [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] fill_r, fill_nxt;
  logic          do_push, do_pop;

  assign q_status.full  = (fill_r == CW'(DEPTH));
  assign q_status.empty = (fill_r == '0);
  assign do_push        = push && !q_status.full;
  assign do_pop         = pop && !q_status.empty;
  assign head           = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (do_push) wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    if (do_pop)  rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    if (do_push && !do_pop) fill_nxt = fill_r + CW'(1);
    else if (do_pop && !do_push) fill_nxt = fill_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr_r] <= push_data;
  end

endmodule

`default_nettype wire

### design/sctok_back.sv
`timescale 1ns / 1ps
`default_nettype none

module sctok_back (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire sctok_pkg::run_t      head,
  input  wire sctok_pkg::q_status_t q_status,
  output logic                      pop,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output sctok_pkg::out_item_t      out_data
);
  import sctok_pkg::*;

  logic [1:0] idx_r, idx_nxt;
  logic       out_valid_r, out_valid_nxt;
  out_item_t  out_data_r;
  logic       load;
  logic       last_rec;

  assign load      = !q_status.empty && (!out_valid_r || out_ready);
  assign last_rec  = (idx_r == head.count - 2'd1);
  assign pop       = load && last_rec;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    if (out_ready) out_valid_nxt = 1'b0;
    if (load) begin
      out_valid_nxt = 1'b1;
      idx_nxt       = last_rec ? 2'd0 : idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && idx_r != 2'd3) out_data_r <= head.recs[idx_r];
  end

endmodule

`default_nettype wire

### design/sctok_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module sctok_checker (
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 out_valid,
  input wire logic                 out_ready,
  input wire sctok_pkg::out_item_t out_data
);
  import sctok_pkg::*;

  // A stalled record holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // End and error records always close the run of their byte.
  a_end_closes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.kind == KIND_END || out_data.kind == KIND_ERROR)
      |-> out_data.last_of_run)
    else $error("end or error record not last of run");

  // Only symbol records carry symbol characters.
  a_sym_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind != KIND_SYMBOL
      |-> out_data.symbol_first == 8'd0 && out_data.symbol_second == 8'd0)
    else $error("symbol field set on non-symbol record");

  // Only close records carry a length.
  a_len_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind != KIND_ID_CLOSE && out_data.kind != KIND_STR_CLOSE
      |-> out_data.text_length == 16'd0)
    else $error("length set on non-close record");

endmodule

bind source_char_tokenizer_core sctok_checker u_sctok_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire
